// File: hw/rtl/debq_pkg.sv
`timescale 1ns / 1ps

package debq_pkg;

   localparam int DEPTH_DEFAULT = 64;

   // request codes carried on req_tuser
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_CLEAR      = 3'd4;
   localparam logic [2:0] REQ_DUMP_FWD   = 3'd5;
   localparam logic [2:0] REQ_DUMP_REV   = 3'd6;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // ring index unit operations
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   localparam int TYPE_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 7;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

endpackage

// File: hw/rtl/debq_ram.sv
`timescale 1ns / 1ps

module debq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hw/rtl/debq_ring_alu.sv
`timescale 1ns / 1ps

module debq_ring_alu import debq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     op,
   input  logic [$clog2(DEPTH)-1:0] a,
   input  logic [$clog2(DEPTH)-1:0] b,
   output logic [$clog2(DEPTH)-1:0] y
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W:0] RING_SIZE = (IDX_W + 1)'(DEPTH);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] diff;
   logic [IDX_W:0] wrapped;

   assign sum  = {1'b0, a} + {1'b0, b};
   assign diff = {1'b0, a} - {1'b0, b};

   always_comb begin
      unique case (op)
         ALU_ADD: begin
            wrapped = (sum >= RING_SIZE) ? sum - RING_SIZE : sum;
         end
         ALU_SUB: begin
            // borrow out of the top bit means the index wrapped below zero
            wrapped = diff[IDX_W] ? diff + RING_SIZE : diff;
         end
         default: begin
            wrapped = sum;
         end
      endcase
   end

   assign y = wrapped[IDX_W-1:0];

endmodule

// File: hw/rtl/double_ended_byte_queue.sv
`timescale 1ns / 1ps
// Push, pop, clear: decoded in the address state, result word registered from the output
// state; no new request until back in idle. Dump of N bytes: N result words, one per cycle
// while the output is not stalled. The byte rate is set by the single registered read port
// of the ring RAM; indexes come from one shared add/subtract-modulo unit, one op per cycle.
// Synchronous active-high reset empties the deque (head and count zero); the RAM
// is not cleared, since entries are read only after they are written.
module double_ended_byte_queue import debq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] data_in
   input  logic [TYPE_W-1:0]      req_tuser,  // [2:0] req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [7:0] data_out, [9:8] status,
                                              // [16:10] occupancy, [23:17] zero
   output logic                   rsp_tlast
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
   localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                from_ram_ff, from_ram_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                alu_op;
   logic [IDX_W-1:0]    alu_a, alu_b, alu_y;
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   logic [BYTE_W-1:0]   rd_data;

   logic                slot_free;
   logic                is_full, is_empty;
   logic [CNT_W-1:0]    cnt_dec;

   debq_ring_alu #(
      .DEPTH(DEPTH)
   ) u_alu (
      .op(alu_op),
      .a (alu_a),
      .b (alu_b),
      .y (alu_y)
   );

   debq_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(data_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign is_full   = (count_ff >= FULL_CNT);
   assign is_empty  = (count_ff == '0);
   assign cnt_dec   = count_ff - ONE_CNT;

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      data_in       = data_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      status_in     = status_ff;
      from_ram_in   = from_ram_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      alu_op        = ALU_ADD;
      alu_a         = head_ff;
      alu_b         = ONE_IDX;
      wr_en         = 1'b0;
      wr_addr       = alu_y;
      rd_en         = 1'b0;
      rd_addr       = alu_y;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               data_in  = req_tdata[BYTE_W-1:0];
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            status_in   = ST_OK;
            from_ram_in = 1'b0;
            left_in     = ONE_CNT;
            state_in    = S_OUT;
            unique case (type_ff) inside
               REQ_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     alu_op   = ALU_SUB;
                     wr_en    = 1'b1;
                     head_in  = alu_y;
                     count_in = count_ff + ONE_CNT;
                  end
               end
               REQ_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     alu_b    = count_ff[IDX_W-1:0];
                     wr_en    = 1'b1;
                     count_in = count_ff + ONE_CNT;
                  end
               end
               REQ_POP_FRONT: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = head_ff;
                     head_in     = alu_y;
                     count_in    = cnt_dec;
                     from_ram_in = 1'b1;
                  end
               end
               REQ_POP_BACK: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     alu_b       = cnt_dec[IDX_W-1:0];
                     rd_en       = 1'b1;
                     count_in    = cnt_dec;
                     from_ram_in = 1'b1;
                  end
               end
               REQ_CLEAR: begin
                  head_in  = '0;
                  count_in = '0;
               end
               REQ_DUMP_FWD, REQ_DUMP_REV: begin
                  if (is_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     // start at the head going forward, at the tail going back
                     alu_b       = (type_ff == REQ_DUMP_FWD) ? '0 : cnt_dec[IDX_W-1:0];
                     rd_en       = 1'b1;
                     pos_in      = alu_y;
                     left_in     = count_ff;
                     from_ram_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = from_ram_ff ? rd_data : '0;
               rsp_status_in = status_ff;
               rsp_occ_in    = OCC_W'(count_ff);
               rsp_last_in   = (left_ff == ONE_CNT);
               if (left_ff == ONE_CNT) begin
                  state_in = S_IDLE;
               end else begin
                  // advance to the next dump position and fetch it
                  alu_op  = (type_ff == REQ_DUMP_FWD) ? ALU_ADD : ALU_SUB;
                  alu_a   = pos_ff;
                  rd_en   = 1'b1;
                  pos_in  = alu_y;
                  left_in = left_ff - ONE_CNT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      data_ff       <= data_in;
      pos_ff        <= pos_in;
      left_ff       <= left_in;
      status_ff     <= status_in;
      from_ram_ff   <= from_ram_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - BYTE_W - STATUS_W - OCC_W)'(0),
                        rsp_occ_ff, rsp_status_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("stored count exceeds depth");

   a_count_changes_in_decode: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == S_ADDR || $past(reset)))
      else $error("stored count changed outside request decode");

   a_dump_left_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && status_ff == ST_OK &&
       (type_ff == REQ_DUMP_FWD || type_ff == REQ_DUMP_REV))
      |-> (left_ff != '0 && left_ff <= count_ff))
      else $error("dump word counter out of range");
`endif

endmodule
